// File: hdl/gne_pkg.sv
// Shared types, codes and helper functions of the grid neighbor expansion block.
package gne_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CoordW = 6;
  localparam int unsigned SizeW = 7;
  localparam int unsigned CostW = 16;
  localparam int unsigned DirW = 3;

  localparam logic [CostW-1:0] COST_IMPASSABLE = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_EIGHT_WAY     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_WIDTH    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GRID_HEIGHT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COST_EMPTY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COST_WATER    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_COST_MOUNTAIN = 3'd5;

  // Request codes.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_EXPAND = 1'b1;

  // Move directions in visiting order.
  localparam logic [DirW-1:0] DIR_UP         = 3'd0;
  localparam logic [DirW-1:0] DIR_DOWN       = 3'd1;
  localparam logic [DirW-1:0] DIR_LEFT       = 3'd2;
  localparam logic [DirW-1:0] DIR_RIGHT      = 3'd3;
  localparam logic [DirW-1:0] DIR_UP_LEFT    = 3'd4;
  localparam logic [DirW-1:0] DIR_UP_RIGHT   = 3'd5;
  localparam logic [DirW-1:0] DIR_DOWN_LEFT  = 3'd6;
  localparam logic [DirW-1:0] DIR_DOWN_RIGHT = 3'd7;

  typedef enum logic [1:0] {
    CELL_EMPTY    = 2'd0,
    CELL_WALL     = 2'd1,
    CELL_WATER    = 2'd2,
    CELL_MOUNTAIN = 2'd3
  } cell_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;    // write one empty entry of the clearing pass
    logic wr_cell;     // store the incoming cell if it lies inside the grid
    logic load_req;    // latch the position to expand, restart the direction
    logic rd_issue;    // read the map at the current neighbor
    logic take_pend;   // hold the current neighbor as the pending result
    logic push_pend;   // move the pending result to the output, not last
    logic push_final;  // move the closing result of the expansion to the output
    logic dir_inc;     // advance to the next direction
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic nbr_in_grid;
    logic walkable;
    logic pend_valid;
    logic out_free;
    logic last_dir;
  } stat_t;

  // Column offset of a move, as a 7-bit two's complement value.
  function automatic logic [SizeW-1:0] dx_off(input logic [DirW-1:0] dir);
    logic [SizeW-1:0] off;
    case (dir)
      DIR_LEFT, DIR_UP_LEFT, DIR_DOWN_LEFT:    off = '1;
      DIR_RIGHT, DIR_UP_RIGHT, DIR_DOWN_RIGHT: off = 7'd1;
      default:                                 off = '0;
    endcase
    return off;
  endfunction

  // Row offset of a move, as a 7-bit two's complement value.
  function automatic logic [SizeW-1:0] dy_off(input logic [DirW-1:0] dir);
    logic [SizeW-1:0] off;
    case (dir)
      DIR_UP, DIR_UP_LEFT, DIR_UP_RIGHT:       off = '1;
      DIR_DOWN, DIR_DOWN_LEFT, DIR_DOWN_RIGHT: off = 7'd1;
      default:                                 off = '0;
    endcase
    return off;
  endfunction

endpackage

// File: hdl/grid_neighbor_expansion.sv
// Top level of the grid neighbor expansion block: controller, datapath and checks.
//
// The block keeps a terrain map of 2-bit cells (empty, wall, water, mountain) in a
// single-port memory of 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries. After reset
// it runs a clearing pass that writes every entry to empty, one per cycle; no input
// transaction is accepted during it, while configuration writes are taken as usual.
// A write transaction stores one cell, if it lies inside the grid, and yields no
// result. An expand transaction visits the up, down, left and right neighbors, then
// the four diagonals when eight_way is set, and yields one result transaction per
// walkable neighbor with last set on the final one, or a single result with found
// low when there is none. The block works on one expansion at a time: each neighbor
// inside the grid takes a map read, then its evaluation, each neighbor outside the
// grid is skipped after its bounds check, and a closing step ends the expansion; a
// stalled output holds the expansion longer. The single map read port and the
// one-entry hold of the pending result set this pace. Results sit in an output
// register, so the next input transaction can be accepted while the last result
// still waits to be taken. The user must see that configuration registers are
// written only while the block is idle; the block itself does not enforce this.
module grid_neighbor_expansion #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [gne_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gne_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [gne_pkg::CoordW-1:0]    cell_x_i,
  input  logic [gne_pkg::CoordW-1:0]    cell_y_i,
  input  logic [1:0]                    cell_type_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [gne_pkg::CoordW-1:0]    next_x_o,
  output logic [gne_pkg::CoordW-1:0]    next_y_o,
  output logic [gne_pkg::DirW-1:0]      move_dir_o,
  output logic [gne_pkg::CostW-1:0]     step_cost_o,
  output logic                          last_o
);
  import gne_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller decides what happens each cycle; the datapath only executes commands.
  gne_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .req_type_i(req_type_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  gne_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cell_x_i   (cell_x_i),
    .cell_y_i   (cell_y_i),
    .cell_type_i(cell_type_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .found_o    (found_o),
    .next_x_o   (next_x_o),
    .next_y_o   (next_y_o),
    .move_dir_o (move_dir_o),
    .step_cost_o(step_cost_o),
    .last_o     (last_o)
  );

  // An accepted expand keeps the input stalled in the following cycle.
  a_expand_blocks_input : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && req_type_i == REQ_EXPAND) |=> in_stall_o
  ) else $error("input accepted right after an expand transaction");

  // A result without a neighbor is always the closing one and carries zero payload.
  a_empty_result_closes : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (last_o && step_cost_o == '0 && move_dir_o == DIR_UP)
  ) else $error("result without neighbor is malformed");

  // A reported neighbor is never impassable.
  a_found_passable : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (step_cost_o != COST_IMPASSABLE)
  ) else $error("impassable neighbor reported");

  // A write transaction never produces a result in the next cycle from an idle output.
  a_write_no_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && req_type_i == REQ_WRITE && !out_valid_o) |=> !out_valid_o
  ) else $error("write transaction produced a result");

endmodule

// File: hdl/gne_ram.sv
// Generic single-port RAM with registered read data.
module gne_ram #(
  parameter int unsigned DATA_W = 2,
  parameter int unsigned DEPTH  = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/gne_datapath.sv
// Datapath: configuration registers, terrain map, neighbor arithmetic and result registers.
module gne_datapath #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gne_pkg::cmd_t                 cmd_i,
  output gne_pkg::stat_t                stat_o,
  input  logic                          cfg_we_i,
  input  logic [gne_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gne_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [gne_pkg::CoordW-1:0]    cell_x_i,
  input  logic [gne_pkg::CoordW-1:0]    cell_y_i,
  input  logic [1:0]                    cell_type_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [gne_pkg::CoordW-1:0]    next_x_o,
  output logic [gne_pkg::CoordW-1:0]    next_y_o,
  output logic [gne_pkg::DirW-1:0]      move_dir_o,
  output logic [gne_pkg::CostW-1:0]     step_cost_o,
  output logic                          last_o
);
  import gne_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned Depth = 2 ** AW;
  localparam logic [10:0] MaxW = 11'(MAX_WIDTH);
  localparam logic [10:0] MaxH = 11'(MAX_HEIGHT);

  // Configuration registers.
  logic             eight_way_q;
  logic [SizeW-1:0] grid_width_q;
  logic [SizeW-1:0] grid_height_q;
  logic [CostW-1:0] cost_empty_q;
  logic [CostW-1:0] cost_water_q;
  logic [CostW-1:0] cost_mountain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eight_way_q     <= 1'b0;
      grid_width_q    <= 7'd64;
      grid_height_q   <= 7'd64;
      cost_empty_q    <= 16'd256;
      cost_water_q    <= 16'd512;
      cost_mountain_q <= 16'd768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EIGHT_WAY:     eight_way_q     <= cfg_wdata_i[0];
        CFG_GRID_WIDTH:    grid_width_q    <= cfg_wdata_i[SizeW-1:0];
        CFG_GRID_HEIGHT:   grid_height_q   <= cfg_wdata_i[SizeW-1:0];
        CFG_COST_EMPTY:    cost_empty_q    <= cfg_wdata_i;
        CFG_COST_WATER:    cost_water_q    <= cfg_wdata_i;
        CFG_COST_MOUNTAIN: cost_mountain_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Position being expanded, current direction and clearing address.
  logic [CoordW-1:0] x_q, y_q;
  logic [DirW-1:0]   dir_q;
  logic [AW-1:0]     clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= DIR_UP;
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.load_req) begin
        dir_q <= DIR_UP;
      end else if (cmd_i.dir_inc) begin
        dir_q <= dir_q + 3'd1;
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      x_q <= cell_x_i;
      y_q <= cell_y_i;
    end
  end

  // Neighbor coordinates; a step below zero wraps to all ones and falls outside the grid.
  logic [SizeW-1:0] nx, ny;
  logic             nbr_in_grid, wr_in_grid;
  logic [AW-1:0]    nbr_addr, wr_addr, ram_addr;
  logic             ram_we, ram_re;
  logic [1:0]       ram_wdata, ram_rdata;

  assign nx = {1'b0, x_q} + dx_off(dir_q);
  assign ny = {1'b0, y_q} + dy_off(dir_q);

  assign nbr_in_grid = (nx < grid_width_q) && (11'(nx) < MaxW) &&
                       (ny < grid_height_q) && (11'(ny) < MaxH);
  assign wr_in_grid  = ({1'b0, cell_x_i} < grid_width_q) && (11'(cell_x_i) < MaxW) &&
                       ({1'b0, cell_y_i} < grid_height_q) && (11'(cell_y_i) < MaxH);

  assign nbr_addr = {YW'(ny), XW'(nx)};
  assign wr_addr  = {YW'(cell_y_i), XW'(cell_x_i)};

  always_comb begin
    if (cmd_i.clr_step) begin
      ram_addr = clr_addr_q;
    end else if (cmd_i.wr_cell) begin
      ram_addr = wr_addr;
    end else begin
      ram_addr = nbr_addr;
    end
  end

  assign ram_we    = cmd_i.clr_step || (cmd_i.wr_cell && wr_in_grid);
  assign ram_re    = cmd_i.rd_issue;
  assign ram_wdata = cmd_i.clr_step ? 2'(CELL_EMPTY) : cell_type_i;

  gne_ram #(
    .DATA_W(2),
    .DEPTH (Depth)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Cost of the neighbor cell just read.
  logic [CostW-1:0] nbr_cost;

  always_comb begin
    case (cell_e'(ram_rdata))
      CELL_EMPTY:    nbr_cost = cost_empty_q;
      CELL_WATER:    nbr_cost = cost_water_q;
      CELL_MOUNTAIN: nbr_cost = cost_mountain_q;
      default:       nbr_cost = COST_IMPASSABLE;
    endcase
  end

  // Pending result: held back until it is known whether it is the last one.
  logic              pend_valid_q;
  logic [CoordW-1:0] pend_x_q, pend_y_q;
  logic [DirW-1:0]   pend_dir_q;
  logic [CostW-1:0]  pend_cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.load_req || cmd_i.push_final) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.take_pend) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pend) begin
      pend_x_q    <= nx[CoordW-1:0];
      pend_y_q    <= ny[CoordW-1:0];
      pend_dir_q  <= dir_q;
      pend_cost_q <= nbr_cost;
    end
  end

  // Output register.
  logic              out_valid_q;
  logic              found_q, last_q;
  logic [CoordW-1:0] next_x_q, next_y_q;
  logic [DirW-1:0]   move_dir_q;
  logic [CostW-1:0]  step_cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_pend || cmd_i.push_final) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_pend || (cmd_i.push_final && pend_valid_q)) begin
      found_q     <= 1'b1;
      next_x_q    <= pend_x_q;
      next_y_q    <= pend_y_q;
      move_dir_q  <= pend_dir_q;
      step_cost_q <= pend_cost_q;
      last_q      <= cmd_i.push_final;
    end else if (cmd_i.push_final) begin
      found_q     <= 1'b0;
      next_x_q    <= '0;
      next_y_q    <= '0;
      move_dir_q  <= DIR_UP;
      step_cost_q <= '0;
      last_q      <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign next_x_o    = next_x_q;
  assign next_y_o    = next_y_q;
  assign move_dir_o  = move_dir_q;
  assign step_cost_o = step_cost_q;
  assign last_o      = last_q;

  assign stat_o.clr_done    = &clr_addr_q;
  assign stat_o.nbr_in_grid = nbr_in_grid;
  assign stat_o.walkable    = (nbr_cost != COST_IMPASSABLE);
  assign stat_o.pend_valid  = pend_valid_q;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;
  assign stat_o.last_dir    = (dir_q == DIR_DOWN_RIGHT) || (!eight_way_q && dir_q == DIR_RIGHT);

endmodule

// File: hdl/gne_ctrl.sv
// Controller state machine that sequences clearing, map writes and neighbor scans.
module gne_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           req_type_i,
  input  gne_pkg::stat_t stat_i,
  output gne_pkg::cmd_t  cmd_o
);
  import gne_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_WRITE) begin
            cmd_o.wr_cell = 1'b1;
          end else begin
            cmd_o.load_req = 1'b1;
            state_d        = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.nbr_in_grid) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_EVAL;
        end else if (stat_i.last_dir) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.dir_inc = 1'b1;
        end
      end
      ST_EVAL: begin
        // A second walkable neighbor needs the output free to pass the first one on.
        if (!(stat_i.walkable && stat_i.pend_valid && !stat_i.out_free)) begin
          cmd_o.take_pend = stat_i.walkable;
          cmd_o.push_pend = stat_i.walkable && stat_i.pend_valid;
          if (stat_i.last_dir) begin
            state_d = ST_FLUSH;
          end else begin
            cmd_o.dir_inc = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end
      ST_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
